FILE: design/qrm_pkg.sv
// Package for the quaternion to rotation matrix block.
// Holds widths and the shared types. No dependencies.
`timescale 1ns / 1ps
package qrm_pkg;
  localparam int COMP_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int OUT_BITS  = FRAC_BITS + 2;
  localparam int PROD_BITS = 2 * COMP_BITS;
  localparam int NORM_BITS = PROD_BITS + 2;
  localparam int NUM_BITS  = PROD_BITS + 2;
  localparam int REM_BITS  = NORM_BITS + 1;
  localparam int Q_BITS    = FRAC_BITS + 2;
  localparam int N_ENT     = 9;
  localparam int N_CELLS   = FRAC_BITS + 1;

  typedef logic signed [COMP_BITS-1:0] comp_t;
  typedef logic signed [OUT_BITS-1:0]  ent_t;

  // One division lane travelling through the cell row.
  typedef struct packed {
    logic                neg;
    logic [REM_BITS-1:0] rem;
    logic [Q_BITS-1:0]   quo;
  } lane_t;

  // Item state shared by all lanes in one cell.
  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic [NORM_BITS-1:0] norm;
  } ctl_t;

  typedef lane_t lanes_t [N_ENT];
endpackage

FILE: design/qrm_if.sv
// Valid/ready channel interfaces for the block.
// Depends on qrm_pkg.
`timescale 1ns / 1ps
interface qrm_in_if;
  import qrm_pkg::*;
  logic  valid;
  logic  ready;
  comp_t comp_w;
  comp_t comp_x;
  comp_t comp_y;
  comp_t comp_z;
  modport source (output valid, comp_w, comp_x, comp_y, comp_z, input ready);
  modport sink (input valid, comp_w, comp_x, comp_y, comp_z, output ready);
endinterface

interface qrm_out_if;
  import qrm_pkg::*;
  logic valid;
  logic ready;
  ent_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic zero_error;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  zero_error, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                zero_error, output ready);
endinterface

FILE: design/qrm_front.sv
// Front stages: products, then numerators and squared norm.
// Depends on qrm_pkg.
`timescale 1ns / 1ps
module qrm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  qrm_pkg::comp_t w,
  input  qrm_pkg::comp_t x,
  input  qrm_pkg::comp_t y,
  input  qrm_pkg::comp_t z,
  output qrm_pkg::ctl_t  ctl,
  output logic signed [qrm_pkg::NUM_BITS-1:0] num [qrm_pkg::N_ENT]
);
  import qrm_pkg::*;
  typedef logic signed [PROD_BITS:0] p_t;
  logic vp;
  p_t ww, xx, yy, zz, xy, zw, xz, yw, yz, xw;
  logic signed [NUM_BITS-1:0] d [N_ENT];
  logic [NORM_BITS-1:0] nsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      vp <= in_valid;
      ctl.valid <= vp;
    end
    if (en) begin
      ww <= p_t'(w * w); xx <= p_t'(x * x); yy <= p_t'(y * y); zz <= p_t'(z * z);
      xy <= p_t'(x * y); zw <= p_t'(z * w); xz <= p_t'(x * z);
      yw <= p_t'(y * w); yz <= p_t'(y * z); xw <= p_t'(x * w);
      ctl.norm <= nsum;
      ctl.zero <= (nsum == '0);
      num <= d;
    end
  end

  always_comb begin
    nsum = NORM_BITS'(ww) + NORM_BITS'(xx) + NORM_BITS'(yy) + NORM_BITS'(zz);
    d[0] = NUM_BITS'(ww) + NUM_BITS'(xx) - NUM_BITS'(yy) - NUM_BITS'(zz);
    d[1] = (NUM_BITS'(xy) - NUM_BITS'(zw)) <<< 1;
    d[2] = (NUM_BITS'(xz) + NUM_BITS'(yw)) <<< 1;
    d[3] = (NUM_BITS'(xy) + NUM_BITS'(zw)) <<< 1;
    d[4] = NUM_BITS'(ww) - NUM_BITS'(xx) + NUM_BITS'(yy) - NUM_BITS'(zz);
    d[5] = (NUM_BITS'(yz) - NUM_BITS'(xw)) <<< 1;
    d[6] = (NUM_BITS'(xz) - NUM_BITS'(yw)) <<< 1;
    d[7] = (NUM_BITS'(yz) + NUM_BITS'(xw)) <<< 1;
    d[8] = NUM_BITS'(ww) - NUM_BITS'(xx) - NUM_BITS'(yy) + NUM_BITS'(zz);
  end
endmodule

FILE: design/qrm_cell.sv
// One restoring-division cell: a quotient bit (the integer part in the first cell) for all nine lanes.
// Depends on qrm_pkg.
`timescale 1ns / 1ps
module qrm_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           first,
  input  qrm_pkg::ctl_t  ctl_in,
  input  qrm_pkg::lane_t lane_in [qrm_pkg::N_ENT],
  output qrm_pkg::ctl_t  ctl_out,
  output qrm_pkg::lane_t lane_out [qrm_pkg::N_ENT]
);
  import qrm_pkg::*;
  lane_t nx [N_ENT];
  logic [REM_BITS-1:0] n;

  always_comb begin
    n = REM_BITS'(ctl_in.norm);
    for (int k = 0; k < N_ENT; k++) begin
      nx[k] = lane_in[k];
      if (first) begin
        // integer part: 0, 1 or 2 (2 only when the remainder is dropped)
        if (lane_in[k].rem >= n) begin
          nx[k].rem = lane_in[k].rem - n;
          nx[k].quo = Q_BITS'(1);
          if (nx[k].rem >= n) begin
            nx[k].rem = '0;
            nx[k].quo = Q_BITS'(2);
          end
        end else begin
          nx[k].quo = '0;
        end
      end else begin
        nx[k].rem = lane_in[k].rem << 1;
        nx[k].quo = {lane_in[k].quo[Q_BITS-2:0], 1'b0};
        if (nx[k].rem >= n) begin
          nx[k].rem = nx[k].rem - n;
          nx[k].quo[0] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ctl_out.valid <= 1'b0;
    else if (en) ctl_out.valid <= ctl_in.valid;
    if (en) begin
      ctl_out.zero <= ctl_in.zero;
      ctl_out.norm <= ctl_in.norm;
      lane_out <= nx;
    end
  end
endmodule

FILE: design/quaternion_to_rotation_matrix_top.sv
// Quaternion to 3x3 rotation matrix, signed fixed point with FRAC_BITS fraction.
// Stages: 2 front stages, FRAC_BITS + 1 division cells, output register with
// rounding in front of it. Throughput: one item per cycle unless the output stalls.
// The front stages, cell row and output register stall as one when the output is held and full.
// Synchronous active-high reset clears all valid flags.
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix_top (
  input logic clk,
  input logic rst,
  qrm_in_if.sink    in_ch,
  qrm_out_if.source out_ch
);
  import qrm_pkg::*;
  logic en;
  ctl_t ctl [N_CELLS+1];
  lane_t lanes [N_CELLS+1][N_ENT];
  logic signed [NUM_BITS-1:0] num [N_ENT];
  ent_t ent_next [N_ENT];
  ent_t ent [N_ENT];
  logic zero_r;
  logic vout;

  assign en = !vout || out_ch.ready;
  assign in_ch.ready = en;

  qrm_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_ch.valid),
    .w(in_ch.comp_w), .x(in_ch.comp_x), .y(in_ch.comp_y), .z(in_ch.comp_z),
    .ctl(ctl[0]), .num(num)
  );

  for (genvar k = 0; k < N_ENT; k++) begin : g_lane0
    assign lanes[0][k].neg = num[k][NUM_BITS-1];
    assign lanes[0][k].rem = REM_BITS'(num[k][NUM_BITS-1] ? -num[k] : num[k]);
    assign lanes[0][k].quo = '0;
  end

  for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
    qrm_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .first(c == 0),
      .ctl_in(ctl[c]), .lane_in(lanes[c]),
      .ctl_out(ctl[c+1]), .lane_out(lanes[c+1])
    );
  end

  // round half away, saturate, apply sign, force zero for a zero norm
  always_comb begin
    logic [Q_BITS:0] q;
    for (int k = 0; k < N_ENT; k++) begin
      q = {1'b0, lanes[N_CELLS][k].quo};
      if ((lanes[N_CELLS][k].rem << 1) >= (REM_BITS+1)'(ctl[N_CELLS].norm)) q = q + 1'b1;
      if (q > (Q_BITS+1)'(1 << FRAC_BITS)) q = (Q_BITS+1)'(1 << FRAC_BITS);
      ent_next[k] = lanes[N_CELLS][k].neg ? -ent_t'(q) : ent_t'(q);
      if (ctl[N_CELLS].zero) ent_next[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else if (en) vout <= ctl[N_CELLS].valid;
    if (en) begin
      ent <= ent_next;
      zero_r <= ctl[N_CELLS].zero;
    end
  end

  assign out_ch.valid = vout;
  assign out_ch.r00 = ent[0];
  assign out_ch.r01 = ent[1];
  assign out_ch.r02 = ent[2];
  assign out_ch.r10 = ent[3];
  assign out_ch.r11 = ent[4];
  assign out_ch.r12 = ent[5];
  assign out_ch.r20 = ent[6];
  assign out_ch.r21 = ent[7];
  assign out_ch.r22 = ent[8];
  assign out_ch.zero_error = zero_r;
endmodule

FILE: bench/qrm_checker.sv
// Checker for the quaternion to rotation matrix block: computes each matrix
// from the accepted quaternion and compares it with the produced one.
// Depends on qrm_pkg and the channel interfaces in qrm_if.
`timescale 1ns / 1ps
module qrm_checker (
  input  logic clk,
  input  logic rst,
  qrm_in_if    in_ch,
  qrm_out_if   out_ch,
  output int   errors,
  output int   pending
);
  import qrm_pkg::*;

  typedef struct {
    ent_t ent [N_ENT];
    logic zero;
  } matrix_t;

  matrix_t matrix_q [$];

  // Round num/n scaled by 2^FRAC_BITS to nearest, ties away from zero, saturating at 2^FRAC_BITS.
  function automatic ent_t scaled_ratio(longint num, longint n);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< (FRAC_BITS + 1)) + n) / (2 * n);
    if (q > (longint'(1) <<< FRAC_BITS)) q = longint'(1) <<< FRAC_BITS;
    if (num < 0) q = -q;
    return ent_t'(q);
  endfunction

  function automatic matrix_t rotation_of(comp_t cw, comp_t cx, comp_t cy, comp_t cz);
    matrix_t m;
    longint w, x, y, z, n;
    longint num [N_ENT];
    w = cw;
    x = cx;
    y = cy;
    z = cz;
    n = w*w + x*x + y*y + z*z;
    m.zero = (n == 0);
    num[0] = w*w + x*x - y*y - z*z;
    num[1] = 2 * (x*y - z*w);
    num[2] = 2 * (x*z + y*w);
    num[3] = 2 * (x*y + z*w);
    num[4] = w*w - x*x + y*y - z*z;
    num[5] = 2 * (y*z - x*w);
    num[6] = 2 * (x*z - y*w);
    num[7] = 2 * (y*z + x*w);
    num[8] = w*w - x*x - y*y + z*z;
    for (int k = 0; k < N_ENT; k++) begin
      m.ent[k] = m.zero ? ent_t'(0) : scaled_ratio(num[k], n);
    end
    return m;
  endfunction

  string ent_name [N_ENT] = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    matrix_t want;
    ent_t got [N_ENT];
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        matrix_q.insert(matrix_q.size(),
                        rotation_of(in_ch.comp_w, in_ch.comp_x, in_ch.comp_y, in_ch.comp_z));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (matrix_q.size() == 0) begin
          $error("matrix produced with no quaternion outstanding");
          errors++;
        end else begin
          want = matrix_q.pop_front();
          got = '{out_ch.r00, out_ch.r01, out_ch.r02, out_ch.r10, out_ch.r11,
                  out_ch.r12, out_ch.r20, out_ch.r21, out_ch.r22};
          for (int k = 0; k < N_ENT; k++) begin
            if (got[k] !== want.ent[k]) begin
              $error("%s: expected %0d, actual %0d", ent_name[k], want.ent[k], got[k]);
              errors++;
            end
          end
          if (out_ch.zero_error !== want.zero) begin
            $error("zero_error: expected %0d, actual %0d", want.zero, out_ch.zero_error);
            errors++;
          end
        end
      end
      pending = matrix_q.size();
    end
  end
endmodule

FILE: bench/quaternion_to_rotation_matrix_top_test.sv
// Testbench top: drives quaternions, applies backpressure and gives the verdict.
// Depends on qrm_pkg, qrm_if, qrm_checker and the block under test.
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix_top_test;
  import qrm_pkg::*;

  localparam int N_RANDOM  = 1630;
  localparam int LIMIT     = 300000;
  localparam int CALM_FROM = 2200;
  localparam int CALM_TO   = 2700;
  localparam int HOLD_AT   = 1500;
  localparam int HOLD_LEN  = 300;
  localparam int DRAIN     = FRAC_BITS + 20;

  logic clk = 0;
  logic rst = 1;
  int   cyc = 0;
  int   errors;
  int   pending;

  qrm_in_if  in_ch ();
  qrm_out_if out_ch ();

  quaternion_to_rotation_matrix_top dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));
  qrm_checker chk (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
                   .errors(errors), .pending(pending));

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bit calm();
    return cyc >= CALM_FROM && cyc < CALM_TO;
  endfunction

  // Offer one quaternion; return at the edge where it is accepted.
  task automatic send(comp_t w, comp_t x, comp_t y, comp_t z);
    while (!calm() && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.comp_w <= w;
    in_ch.comp_x <= x;
    in_ch.comp_y <= y;
    in_ch.comp_z <= z;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic comp_t rand_comp(int mode);
    case (mode)
      0: return comp_t'($urandom);
      1: return comp_t'($urandom_range(8) - 4);
      default: return comp_t'($urandom_range(512) - 256);
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off, a calm stretch.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cyc == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (calm()) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 37);
      end
    end
  end

  initial begin
    comp_t dir [$][4];
    int mode;
    in_ch.valid  <= 1'b0;
    in_ch.comp_w <= '0;
    in_ch.comp_x <= '0;
    in_ch.comp_y <= '0;
    in_ch.comp_z <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero quaternion, extremes, single axes, sign flip, small mixed values
    dir = '{'{0, 0, 0, 0}, '{-32768, -32768, -32768, -32768},
            '{32767, 32767, 32767, 32767}, '{-32768, 0, 0, 0},
            '{0, -32768, 0, 0}, '{0, 0, -32768, 0}, '{0, 0, 0, -32768},
            '{32767, 0, 0, 0}, '{0, 32767, 0, 0}, '{0, 0, 32767, 0},
            '{0, 0, 0, 32767}, '{1, 1, 1, 1}, '{-1, -1, -1, -1},
            '{1, 0, 0, 1}, '{-1, 0, 0, -1}, '{32767, -32768, 32767, -32768},
            '{-32768, 32767, -32768, 32767}, '{1, 2, 0, 0}, '{3, 0, 1, 0},
            '{0, 0, 0, 1}, '{1, 0, 0, 0}, '{12345, -23456, 7, -32768},
            '{2, 1, 1, 1}, '{-32768, 32767, 0, 1}};
    foreach (dir[i]) send(dir[i][0], dir[i][1], dir[i][2], dir[i][3]);

    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(9);
      if (mode < 5) begin
        send(rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0));
      end else if (mode < 7) begin
        send(rand_comp(1), rand_comp(1), rand_comp(1), rand_comp(1));
      end else if (mode < 9) begin
        send(rand_comp(0), rand_comp(2), rand_comp(1), rand_comp(2));
      end else begin
        send(rand_comp(1), rand_comp(0), rand_comp(2), rand_comp(0));
      end
    end
    in_ch.valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
